// ===== design/byte_ring_fifo_unit_assert.svh =====
// Assertion macros for the byte ring FIFO unit.
`ifndef BYTE_RING_FIFO_UNIT_ASSERT_SVH
`define BYTE_RING_FIFO_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BRF_ASSERT_CR(lbl, clk_i, rst_ni, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("byte ring fifo assertion failed");
`define BRF_ASSERT(lbl, prop) \
  `BRF_ASSERT_CR(lbl, clk, rst_n, prop)
`else
`define BRF_ASSERT_CR(lbl, clk_i, rst_ni, prop)
`define BRF_ASSERT(lbl, prop)
`endif
`endif

// ===== design/brf_pkg.sv =====
// Types, codes and constants shared by the byte ring FIFO modules.
package brf_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned SIZE_W        = 11;
  localparam int unsigned LEN_W         = 10;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [2:0] FUNC_WRITE   = 3'd0;
  localparam logic [2:0] FUNC_READ    = 3'd1;
  localparam logic [2:0] FUNC_PEEK    = 3'd2;
  localparam logic [2:0] FUNC_DISCARD = 3'd3;
  localparam logic [2:0] FUNC_CLEAR   = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]       func;
    logic [7:0]       write_data;
    logic [LEN_W-1:0] drop_len;
    logic [LEN_W-1:0] peek_offset;
  } brf_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       read_data;
    logic [LEN_W-1:0] dropped;
    logic [LEN_W-1:0] fill_count;
    logic [LEN_W-1:0] free_space;
    logic             empty_flag;
    logic             full_flag;
  } brf_rsp_t;

  // per-request outcome handed from pointer logic to the output stage
  typedef struct packed {
    logic [1:0]       status;
    logic             rd_sel;
    logic [LEN_W-1:0] dropped;
  } brf_meta_t;

  // fill state after the last operation
  typedef struct packed {
    logic [LEN_W-1:0] fill_count;
    logic [LEN_W-1:0] free_space;
    logic             empty_flag;
    logic             full_flag;
  } brf_fill_t;

endpackage

// ===== design/brf_mem.sv =====
// Byte store: one write port, one read port with registered read data.
module brf_mem #(
  parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);
  import brf_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/brf_ptr.sv =====
// Pointer, count and size state; decodes each request into store accesses.
`include "byte_ring_fifo_unit_assert.svh"
module brf_ptr #(
  parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [brf_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic                          req_acc,
  input  brf_pkg::brf_req_t             req,
  output brf_pkg::brf_meta_t            meta,
  output brf_pkg::brf_fill_t            fill,
  output logic                          mem_we,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr,
  output logic [7:0]                    mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr
);
  import brf_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned AW = (PW + 1 > SIZE_W) ? PW + 1 : SIZE_W;

  logic [SIZE_W-1:0] size_r;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic [PW-1:0]     cnt_r, cnt_nxt;

  logic [AW-1:0] size_w, eff_s, cap, cnt_w, wp_w, rp_w;
  logic [AW-1:0] wp_inc, wp_wrap, rp_inc, rp_wrap;
  logic [AW-1:0] dlen_w, drop_w, rp_sum, rp_disc, poff_w, pk_sum, pk_addr;
  logic [AW-1:0] free_w;
  logic          is_full, ring_empty;

  always_comb begin
    size_w = AW'(size_r);
    if (size_w < AW'(2)) begin
      eff_s = AW'(2);
    end else if (size_w > AW'(DEPTH)) begin
      eff_s = AW'(DEPTH);
    end else begin
      eff_s = size_w;
    end
  end

  assign cap        = eff_s - AW'(1);
  assign cnt_w      = AW'(cnt_r);
  assign wp_w       = AW'(wp_r);
  assign rp_w       = AW'(rp_r);
  assign is_full    = (cnt_w == cap);
  assign ring_empty = (cnt_r == '0);

  assign wp_inc  = wp_w + AW'(1);
  assign wp_wrap = (wp_inc == eff_s) ? '0 : wp_inc;
  assign rp_inc  = rp_w + AW'(1);
  assign rp_wrap = (rp_inc == eff_s) ? '0 : rp_inc;

  // discard length is cut to the count; sum stays below twice the size
  assign dlen_w  = AW'(req.drop_len);
  assign drop_w  = (dlen_w < cnt_w) ? dlen_w : cnt_w;
  assign rp_sum  = rp_w + drop_w;
  assign rp_disc = (rp_sum >= eff_s) ? rp_sum - eff_s : rp_sum;

  assign poff_w  = AW'(req.peek_offset);
  assign pk_sum  = rp_w + poff_w;
  assign pk_addr = (pk_sum >= eff_s) ? pk_sum - eff_s : pk_sum;

  always_comb begin
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    cnt_nxt     = cnt_r;
    meta        = '0;
    mem_we      = 1'b0;
    mem_waddr   = wp_r;
    mem_wdata   = req.write_data;
    mem_re      = 1'b0;
    mem_raddr   = rp_r;
    unique case (req.func)
      FUNC_WRITE: begin
        if (is_full) begin
          meta.status = STATUS_FULL;
        end else begin
          mem_we  = req_acc;
          wp_nxt  = wp_wrap[PW-1:0];
          cnt_nxt = cnt_r + PW'(1);
        end
      end
      FUNC_READ: begin
        if (ring_empty) begin
          meta.status = STATUS_EMPTY;
        end else begin
          mem_re      = req_acc;
          meta.rd_sel = 1'b1;
          rp_nxt      = rp_wrap[PW-1:0];
          cnt_nxt     = cnt_r - PW'(1);
        end
      end
      FUNC_PEEK: begin
        if (poff_w >= cnt_w) begin
          meta.status = STATUS_EMPTY;
        end else begin
          mem_re      = req_acc;
          mem_raddr   = pk_addr[PW-1:0];
          meta.rd_sel = 1'b1;
        end
      end
      FUNC_DISCARD: begin
        meta.dropped = drop_w[LEN_W-1:0];
        rp_nxt       = rp_disc[PW-1:0];
        cnt_nxt      = cnt_r - drop_w[PW-1:0];
      end
      FUNC_CLEAR: begin
        wp_nxt  = '0;
        rp_nxt  = '0;
        cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // a size write also empties the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
    end else if (req_acc) begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign free_w          = cap - cnt_w;
  assign fill.fill_count = cnt_w[LEN_W-1:0];
  assign fill.free_space = free_w[LEN_W-1:0];
  assign fill.empty_flag = ring_empty;
  assign fill.full_flag  = is_full;

  `BRF_ASSERT(a_cnt_cap, cnt_w <= cap)
  `BRF_ASSERT(a_ptr_range, (wp_w < eff_s) && (rp_w < eff_s))
  `BRF_ASSERT(a_one_port, !(mem_we && mem_re))
  `BRF_ASSERT(a_write_cnt, req_acc && !cfg_we && mem_we |=> cnt_r == $past(cnt_r) + PW'(1))

endmodule

// ===== design/byte_ring_fifo_unit.sv =====
// Top level of the byte ring FIFO unit: handshake, store and result register.
// Results are registered: a result becomes valid in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; a stalled result holds
// off the next request. Each request reads or writes the store at most once.
// Reset: pointers and count go to zero and the size register to 1024.
// Store contents are not cleared by reset and need no clearing pass.
module byte_ring_fifo_unit #(
  parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  brf_pkg::brf_req_t          in_req,
  output logic                       out_valid,
  input  logic                       out_stall,
  output brf_pkg::brf_rsp_t          out_rsp,
  input  logic                       cfg_we,
  input  logic [brf_pkg::SIZE_W-1:0] cfg_wdata
);
  import brf_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);

  logic          in_acc;
  logic          out_valid_r, out_valid_nxt;
  brf_meta_t     meta, meta_r;
  brf_fill_t     fill;
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // result register frees up in the same cycle it is taken
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  brf_ptr #(.DEPTH(DEPTH)) u_ptr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_acc   (in_acc),
    .req       (in_req),
    .meta      (meta),
    .fill      (fill),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr)
  );

  // read data register inside the store doubles as the result data stage
  brf_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      meta_r <= meta;
    end
  end

  // fill fields follow the state registers, which change on the same edge
  // that loads the next result, or on a size write or reset
  assign out_valid          = out_valid_r;
  assign out_rsp.status     = meta_r.status;
  assign out_rsp.read_data  = meta_r.rd_sel ? mem_rdata : 8'd0;
  assign out_rsp.dropped    = meta_r.dropped;
  assign out_rsp.fill_count = fill.fill_count;
  assign out_rsp.free_space = fill.free_space;
  assign out_rsp.empty_flag = fill.empty_flag;
  assign out_rsp.full_flag  = fill.full_flag;

endmodule

// ===== dv/byte_ring_fifo_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for byte_ring_fifo_unit: directed, random and capacity-sweep requests.
module byte_ring_fifo_unit_test;
  import brf_pkg::*;

  // Scoreboard: keeps a shadow ring (store, pointers, size register), works out
  // the response each accepted request must produce and checks responses in order.
  class fifo_scoreboard;
    bit [7:0]        byte_mem [1024];
    bit [LEN_W-1:0]  wr_ptr;
    bit [LEN_W-1:0]  rd_ptr;
    bit [SIZE_W-1:0] size_reg;
    brf_rsp_t        pending_rsp [$];
    int unsigned     mismatches;
    int unsigned     results_seen;
    int unsigned     full_refusals;
    int unsigned     empty_refusals;

    function new();
      size_reg = SIZE_RESET;
      wr_ptr = '0;
      rd_ptr = '0;
      foreach (byte_mem[i]) byte_mem[i] = '0;
    endfunction

    // a size register write always empties the ring; store contents survive
    function void set_size(bit [SIZE_W-1:0] v);
      size_reg = v;
      wr_ptr = '0;
      rd_ptr = '0;
    endfunction

    // slots in use, with out-of-range settings clamped to 2..1024
    function int unsigned ring_slots();
      if (size_reg < 2) return 2;
      if (size_reg > 1024) return 1024;
      return 32'(size_reg);
    endfunction

    function bit [LEN_W-1:0] step_ptr(bit [LEN_W-1:0] p, int unsigned add, int unsigned s);
      int unsigned v;
      v = p + add;
      while (v >= s) v -= s;
      return v[LEN_W-1:0];
    endfunction

    function int unsigned held(int unsigned s);
      if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
      return s - rd_ptr + wr_ptr;
    endfunction

    function int unsigned held_now();
      return held(ring_slots());
    endfunction

    function int unsigned outstanding();
      return pending_rsp.size();
    endfunction

    function brf_rsp_t predict(brf_req_t r);
      int unsigned s;
      int unsigned cnt;
      int unsigned drop;
      bit [LEN_W-1:0] nxt;
      brf_rsp_t o;
      s = ring_slots();
      if (wr_ptr >= s) wr_ptr = '0;
      if (rd_ptr >= s) rd_ptr = '0;
      cnt = held(s);
      o = '0;
      case (r.func)
        FUNC_WRITE: begin
          nxt = step_ptr(wr_ptr, 1, s);
          if (nxt == rd_ptr) begin
            o.status = STATUS_FULL;
            full_refusals++;
          end else begin
            byte_mem[wr_ptr] = r.write_data;
            wr_ptr = nxt;
          end
        end
        FUNC_READ: begin
          if (cnt == 0) begin
            o.status = STATUS_EMPTY;
            empty_refusals++;
          end else begin
            o.read_data = byte_mem[rd_ptr];
            rd_ptr = step_ptr(rd_ptr, 1, s);
          end
        end
        FUNC_PEEK: begin
          if (r.peek_offset >= cnt) begin
            o.status = STATUS_EMPTY;
            empty_refusals++;
          end else begin
            o.read_data = byte_mem[step_ptr(rd_ptr, r.peek_offset, s)];
          end
        end
        FUNC_DISCARD: begin
          drop = (r.drop_len < cnt) ? r.drop_len : cnt;
          o.dropped = drop[LEN_W-1:0];
          rd_ptr = step_ptr(rd_ptr, drop, s);
        end
        FUNC_CLEAR: begin
          wr_ptr = '0;
          rd_ptr = '0;
        end
        default: ;
      endcase
      cnt = held(s);
      o.fill_count = cnt[LEN_W-1:0];
      o.free_space = LEN_W'(s - 1 - cnt);
      o.empty_flag = (wr_ptr == rd_ptr);
      o.full_flag  = (step_ptr(wr_ptr, 1, s) == rd_ptr);
      return o;
    endfunction

    function void note_request(brf_req_t r);
      pending_rsp.push_back(predict(r));
    endfunction

    task log_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task field_check(string name, logic [LEN_W-1:0] got, logic [LEN_W-1:0] want);
      if (got !== want)
        log_mismatch($sformatf("response %0d %s got %0h want %0h",
                               results_seen, name, got, want));
    endtask

    task check_result(brf_rsp_t got);
      brf_rsp_t want;
      if (pending_rsp.size() == 0) begin
        log_mismatch($sformatf("response with no request outstanding: %0h", got));
        return;
      end
      want = pending_rsp.pop_front();
      field_check("status",     LEN_W'(got.status),     LEN_W'(want.status));
      field_check("read_data",  LEN_W'(got.read_data),  LEN_W'(want.read_data));
      field_check("dropped",    got.dropped,            want.dropped);
      field_check("fill_count", got.fill_count,         want.fill_count);
      field_check("free_space", got.free_space,         want.free_space);
      field_check("empty_flag", LEN_W'(got.empty_flag), LEN_W'(want.empty_flag));
      field_check("full_flag",  LEN_W'(got.full_flag),  LEN_W'(want.full_flag));
      results_seen++;
    endtask
  endclass

  localparam int unsigned CLK_PERIOD = 12;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_RANDOM,
    STALL_TOGGLE,
    STALL_BURSTS
  } stall_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  brf_req_t              in_req;
  logic                  out_valid;
  logic                  out_stall;
  brf_rsp_t              out_rsp;
  logic                  cfg_we;
  logic [SIZE_W-1:0]     cfg_wdata;

  fifo_scoreboard sb;
  int unsigned    requests_sent;
  int unsigned    sizes_programmed;

  byte_ring_fifo_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // Response monitor: a response moves on a rising edge with valid high and
  // stall low; it is compared against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_rsp);
  end

  // Receiver backpressure. Every so often a new pattern is chosen: no stall at
  // all, random stalls, alternating stall and no stall, or random runs of
  // stalled cycles. Driven at the falling edge so the block sees a settled value.
  initial begin
    stall_mode_e mode;
    int unsigned span;
    int unsigned hold;
    out_stall = 1'b0;
    mode = STALL_NONE;
    span = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        span = $urandom_range(20, 150);
      end
      span--;
      case (mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_TOGGLE: out_stall <= ~out_stall;
        default: begin
          if (hold > 0) begin
            hold--;
            out_stall <= 1'b1;
          end else if ($urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 8);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  function automatic brf_req_t mk(logic [2:0] fn, logic [7:0] wd,
                                  logic [LEN_W-1:0] dl, logic [LEN_W-1:0] po);
    brf_req_t r;
    r.func        = fn;
    r.write_data  = wd;
    r.drop_len    = dl;
    r.peek_offset = po;
    return r;
  endfunction

  // Present one request and hold it until accepted. Called at a falling edge
  // and returns at a falling edge, so back-to-back calls keep valid high
  // without ever dropping it inside a time step.
  task automatic push_req(brf_req_t r);
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(r);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Stop sending and let every outstanding response come back. The cap only
  // guards against a hung block; leftovers are caught at the end.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.outstanding() > 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    // then let the block settle idle before returning
    repeat (2) @(negedge clk);
  endtask

  // Size register write, only with nothing in flight.
  task automatic program_size(logic [SIZE_W-1:0] v);
    drain_results();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_size(v);
    sizes_programmed++;
  endtask

  // Random request. fill_lean tilts the mix toward writes so small rings hit
  // full; otherwise reads and peeks dominate and the ring drains. Offsets and
  // discard lengths mostly land around the current fill so both sides of the
  // boundary are hit, with some full-range values for bit coverage.
  function automatic brf_req_t gen_req(bit fill_lean);
    brf_req_t    r;
    int unsigned pick;
    int unsigned cnt;
    cnt  = sb.held_now();
    pick = $urandom_range(0, 99);
    r.write_data  = 8'($urandom);
    r.drop_len    = ($urandom_range(0, 9) < 7) ? LEN_W'($urandom_range(0, cnt + 2)) :
                                                 LEN_W'($urandom_range(0, 1023));
    r.peek_offset = ($urandom_range(0, 9) < 8) ? LEN_W'($urandom_range(0, cnt)) :
                                                 LEN_W'($urandom_range(0, 1023));
    if (pick < (fill_lean ? 55 : 25))      r.func = FUNC_WRITE;
    else if (pick < (fill_lean ? 72 : 58)) r.func = FUNC_READ;
    else if (pick < 86)                    r.func = FUNC_PEEK;
    else if (pick < 95)                    r.func = FUNC_DISCARD;
    else if (pick < 97)                    r.func = FUNC_CLEAR;
    else                                   r.func = 3'($urandom_range(FUNC_CLEAR + 1, 7));
    return r;
  endfunction

  // Bursty sender: random burst lengths, random gaps, back-to-back stretches,
  // and now and then a full drain before carrying on.
  task automatic run_random(int unsigned n);
    int unsigned done;
    int unsigned burst;
    bit          lean;
    done = 0;
    while (done < n) begin
      burst = $urandom_range(1, 24);
      lean  = $urandom_range(0, 1);
      for (int unsigned i = 0; i < burst && done < n; i++) begin
        push_req(gen_req(lean));
        done++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ;
        9:          drain_results();
        default:    idle_sender($urandom_range(1, 6));
      endcase
    end
  endtask

  // Directed corner cases at the reset size, then at the smallest ring.
  task automatic run_directed();
    push_req(mk(FUNC_READ,    8'hff, 10'h3ff, 10'h3ff));  // read on empty
    push_req(mk(FUNC_PEEK,    8'h00, 10'h000, 10'h000));  // peek on empty
    push_req(mk(FUNC_DISCARD, 8'h00, 10'h3ff, 10'h000));  // discard on empty drops 0
    push_req(mk(FUNC_WRITE,   8'h00, 10'h000, 10'h000));
    push_req(mk(FUNC_WRITE,   8'hff, 10'h3ff, 10'h3ff));
    push_req(mk(FUNC_PEEK,    8'h00, 10'h000, 10'h000));  // oldest byte
    push_req(mk(FUNC_PEEK,    8'h00, 10'h000, 10'h001));  // newest byte
    push_req(mk(FUNC_PEEK,    8'h00, 10'h000, 10'h002));  // offset equals count
    push_req(mk(FUNC_PEEK,    8'h00, 10'h000, 10'h3ff));  // offset far past count
    push_req(mk(FUNC_CLEAR + 3'd1, 8'hff, 10'h3ff, 10'h3ff));  // unused codes
    push_req(mk(FUNC_CLEAR + 3'd2, 8'h00, 10'h000, 10'h000));
    push_req(mk(3'd7,         8'h5a, 10'h155, 10'h2aa));
    push_req(mk(FUNC_DISCARD, 8'h00, 10'h000, 10'h000));  // zero-length discard
    push_req(mk(FUNC_READ,    8'h00, 10'h000, 10'h000));
    push_req(mk(FUNC_DISCARD, 8'h00, 10'h3ff, 10'h000));  // length cut to count
    push_req(mk(FUNC_WRITE,   8'ha5, 10'h000, 10'h000));
    push_req(mk(FUNC_CLEAR,   8'h00, 10'h000, 10'h000));
    // size 0 acts as 2: capacity of a single byte
    program_size(11'd0);
    push_req(mk(FUNC_WRITE,   8'h5a, 10'h000, 10'h000));
    push_req(mk(FUNC_WRITE,   8'hc3, 10'h000, 10'h000));  // refused, full
    push_req(mk(FUNC_READ,    8'h00, 10'h000, 10'h000));
    push_req(mk(FUNC_READ,    8'h00, 10'h000, 10'h000));  // refused, empty
  endtask

  // Fill a ring to capacity, then walk both pointers across the top of its
  // range and back to zero.
  task automatic capacity_sweep(int unsigned slots);
    logic [LEN_W-1:0] cap;
    cap = LEN_W'(slots - 1);
    program_size(SIZE_W'(slots));
    repeat (slots - 1)
      push_req(mk(FUNC_WRITE, 8'($urandom), LEN_W'($urandom), LEN_W'($urandom)));
    push_req(mk(FUNC_WRITE,   8'h99,   10'h000, 10'h000));   // refused when full
    push_req(mk(FUNC_PEEK,    8'h00,   10'h000, cap - 1'b1)); // last valid offset
    push_req(mk(FUNC_PEEK,    8'h00,   10'h000, cap));        // offset equals count
    push_req(mk(FUNC_READ,    8'h00,   10'h000, 10'h000));
    push_req(mk(FUNC_WRITE,   8'h66,   10'h000, 10'h000));   // write pointer wraps
    push_req(mk(FUNC_PEEK,    8'h00,   10'h000, cap - 1'b1)); // byte stored at the top
    push_req(mk(FUNC_DISCARD, 8'h00,   10'h3ff, 10'h000));   // read pointer wraps
    push_req(mk(FUNC_READ,    8'h00,   10'h000, 10'h000));
    run_random(20);
  endtask

  initial begin
    bit [SIZE_W-1:0] ring_sizes [10];
    ring_sizes = '{11'd3, 11'd2047, 11'd2, 11'd5, 11'd1, 11'd17, 11'd64, 11'd7,
                   11'd1024, 11'd33};
    sb = new();
    requests_sent    = 0;
    sizes_programmed = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    // small rings get most of the traffic so full and wrap come up often
    foreach (ring_sizes[i]) begin
      program_size(ring_sizes[i]);
      run_random(40);
    end
    capacity_sweep(256);

    drain_results();
    if (sb.outstanding() > 0)
      sb.log_mismatch($sformatf("%0d responses never arrived", sb.outstanding()));
    $display("covered %0d requests over %0d size settings, %0d responses compared",
             requests_sent, sizes_programmed, sb.results_seen);
    $display("writes refused on full: %0d, reads/peeks refused on empty: %0d",
             sb.full_refusals, sb.empty_refusals);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(CLK_PERIOD * 400000);
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/brf_pkg.sv
design/brf_mem.sv
design/brf_ptr.sv
design/byte_ring_fifo_unit.sv
dv/byte_ring_fifo_unit_test.sv
